>>> rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared constants, types and tables of the polar/cartesian CORDIC converter.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int ITERATIONS  = 16;
   localparam int GUARD       = 8;
   localparam int ITER_USED   = (ITERATIONS < 24) ? ITERATIONS : 24;
   localparam int IDX_W       = (ITER_USED > 1) ? $clog2(ITER_USED) : 1;
   localparam int ATAN_DEPTH  = 24;
   localparam int ATAN_IDX_W  = 5;

   localparam int IN_W        = 16;
   localparam int RES_W       = 17;
   localparam int XY_W        = IN_W + GUARD + 4;
   localparam int ANG_FRAC    = 30;
   localparam int Z_W         = 34;
   localparam int GAIN_W      = 31;
   localparam int PROD_W      = XY_W + GAIN_W;
   localparam int CHK_W       = 40;

   localparam longint PI_APPROX_Q32 = 64'sd13493026307;
   localparam longint PI_APPROX_Q30 = (PI_APPROX_Q32 + 2) / 4;
   localparam longint PI_Q30        = 64'sd3373259426;
   localparam longint HALF_PI_Q30   = 64'sd1686629713;
   localparam longint GAIN_Q30      = 64'sd652032874;
   localparam longint HALF_PI_RND   =
      (HALF_PI_Q30 + (64'sd1 <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);

   localparam logic CMD_POLAR     = 1'b0;
   localparam logic CMD_CARTESIAN = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NEG_RADIUS = 2'd1,
      STATUS_BAD_ANGLE  = 2'd2
   } pcc_status_type;

   // Q30 arctangent of 2^-i, truncated
   localparam logic [ANG_FRAC-1:0] ATAN_Q30 [ATAN_DEPTH] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
      30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
      30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
      30'd262143,    30'd131071,    30'd65535,     30'd32767,
      30'd16383,     30'd8191,      30'd4095,      30'd2047,
      30'd1023,      30'd511,       30'd255,       30'd127
   };

   typedef struct packed {
      logic                    vec_mode;
      logic                    fix_pi;
      logic                    pi_neg;
      logic                    bypass;
      pcc_status_type          status;
      logic signed [RES_W-1:0] byp_first;
      logic signed [RES_W-1:0] byp_second;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
   } pcc_data_type;

endpackage

>>> rtl/core/pcc_prep.sv
// ----------------------------------------------------------------------------
// pcc_prep
// Input stage: range checks, special cases and start vector of the CORDIC.
// ----------------------------------------------------------------------------
module pcc_prep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic                             cmd,
   input  logic signed [pcc_pkg::IN_W-1:0]  first_value,
   input  logic signed [pcc_pkg::IN_W-1:0]  second_value,
   output logic                             out_valid,
   output pcc_pkg::pcc_data_type            out_data
);
   import pcc_pkg::*;

   localparam logic signed [CHK_W-1:0] PI_CHK      = CHK_W'(PI_APPROX_Q32);
   localparam logic signed [Z_W-1:0]   PI_Z        = Z_W'(PI_Q30);
   localparam logic signed [Z_W-1:0]   HALF_PI_Z   = Z_W'(HALF_PI_Q30);
   localparam logic signed [RES_W-1:0] HALF_PI_RES = RES_W'(HALF_PI_RND);

   logic                      valid_ff;
   pcc_data_type              data_ff;
   pcc_data_type              data_in;
   logic signed [XY_W-1:0]    a_ext;
   logic signed [XY_W-1:0]    b_ext;
   logic signed [XY_W-1:0]    x_rot;
   logic signed [CHK_W-1:0]   b_chk;
   logic signed [Z_W-1:0]     z_rot;
   logic signed [RES_W-1:0]   b_res;

   always_comb begin
      a_ext   = XY_W'(first_value);
      b_ext   = XY_W'(second_value);
      b_chk   = CHK_W'(second_value) <<< (32 - FRAC_BITS);
      z_rot   = Z_W'(second_value) <<< (ANG_FRAC - FRAC_BITS);
      x_rot   = a_ext <<< GUARD;
      b_res   = RES_W'(second_value);
      data_in = '0;
      data_in.status = STATUS_OK;
      if (cmd == CMD_POLAR) begin
         if (first_value < 0) begin
            data_in.bypass = 1'b1;
            data_in.status = STATUS_NEG_RADIUS;
         end else if (b_chk > PI_CHK || b_chk < -PI_CHK) begin
            data_in.bypass = 1'b1;
            data_in.status = STATUS_BAD_ANGLE;
         end
         // fold angles beyond +/-pi/2 back by pi and flip the vector
         if (z_rot > HALF_PI_Z) begin
            data_in.z = z_rot - PI_Z;
            data_in.x = -x_rot;
         end else if (z_rot < -HALF_PI_Z) begin
            data_in.z = z_rot + PI_Z;
            data_in.x = -x_rot;
         end else begin
            data_in.z = z_rot;
            data_in.x = x_rot;
         end
      end else begin
         data_in.vec_mode = 1'b1;
         if (first_value == 0) begin
            data_in.bypass    = 1'b1;
            data_in.byp_first = (second_value < 0) ? -b_res : b_res;
            if (second_value > 0) begin
               data_in.byp_second = HALF_PI_RES;
            end else if (second_value < 0) begin
               data_in.byp_second = -HALF_PI_RES;
            end
         end
         data_in.fix_pi = first_value < 0;
         data_in.pi_neg = second_value < 0;
         data_in.x = ((first_value < 0) ? -a_ext : a_ext) <<< GUARD;
         data_in.y = ((first_value < 0) ? -b_ext : b_ext) <<< GUARD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/pcc_cell.sv
// ----------------------------------------------------------------------------
// pcc_cell
// One CORDIC micro-rotation with its stage register.
// ----------------------------------------------------------------------------
module pcc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic [pcc_pkg::IDX_W-1:0]     shift,
   input  logic                          in_valid,
   input  pcc_pkg::pcc_data_type         in_data,
   output logic                          out_valid,
   output pcc_pkg::pcc_data_type         out_data
);
   import pcc_pkg::*;

   logic                    valid_ff;
   pcc_data_type            data_ff;
   pcc_data_type            data_in;
   logic signed [XY_W-1:0]  x_cur;
   logic signed [XY_W-1:0]  y_cur;
   logic signed [Z_W-1:0]   z_cur;
   logic signed [XY_W-1:0]  x_sh;
   logic signed [XY_W-1:0]  y_sh;
   logic signed [Z_W-1:0]   atan_z;
   logic                    ccw;

   always_comb begin
      x_cur  = in_data.x;
      y_cur  = in_data.y;
      z_cur  = in_data.z;
      x_sh   = x_cur >>> shift;
      y_sh   = y_cur >>> shift;
      atan_z = Z_W'(ATAN_Q30[ATAN_IDX_W'(shift)]);
      // rotation drives z to zero, vectoring drives y to zero
      ccw    = in_data.vec_mode ? y_cur[XY_W-1] : !z_cur[Z_W-1];
      data_in = in_data;
      if (ccw) begin
         data_in.x = x_cur - y_sh;
         data_in.y = y_cur + x_sh;
         data_in.z = z_cur - atan_z;
      end else begin
         data_in.x = x_cur + y_sh;
         data_in.y = y_cur - x_sh;
         data_in.z = z_cur + atan_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/pcc_post.sv
// ----------------------------------------------------------------------------
// pcc_post
// Gain correction, quadrant fix of the angle, rounding and saturation.
// ----------------------------------------------------------------------------
module pcc_post (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  pcc_pkg::pcc_data_type             in_data,
   output logic                              out_valid,
   output logic signed [pcc_pkg::RES_W-1:0]  first_result,
   output logic signed [pcc_pkg::RES_W-1:0]  second_result,
   output logic [1:0]                        status
);
   import pcc_pkg::*;

   localparam int GAIN_SHIFT = ANG_FRAC + GUARD;
   localparam int ANG_SHIFT  = ANG_FRAC - FRAC_BITS;
   localparam logic signed [GAIN_W-1:0] GAIN_S   = GAIN_W'(GAIN_Q30);
   localparam logic signed [Z_W-1:0]    PI_AP_Z  = Z_W'(PI_APPROX_Q30);
   localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(64'sd1 <<< (GAIN_SHIFT - 1));
   localparam logic signed [Z_W:0]      ANG_RND  = (Z_W + 1)'(64'sd1 <<< (ANG_SHIFT - 1));
   localparam longint RES_MAX = (64'sd1 <<< (RES_W - 1)) - 1;
   localparam longint RES_MIN = -(64'sd1 <<< (RES_W - 1));

   function automatic logic signed [RES_W-1:0] sat_res(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = v;
      if (v > RES_MAX) begin
         c = RES_MAX;
      end else if (v < RES_MIN) begin
         c = RES_MIN;
      end
      return RES_W'(c);
   endfunction

   logic                    valid_ff;
   logic                    vec_mode_ff;
   logic                    bypass_ff;
   pcc_status_type          status_ff;
   logic signed [RES_W-1:0] byp_first_ff;
   logic signed [RES_W-1:0] byp_second_ff;
   logic signed [PROD_W-1:0] prod_x_ff;
   logic signed [PROD_W-1:0] prod_x_in;
   logic signed [PROD_W-1:0] prod_y_ff;
   logic signed [PROD_W-1:0] prod_y_in;
   logic signed [Z_W-1:0]   z_ff;
   logic signed [Z_W-1:0]   z_in;
   logic signed [XY_W-1:0]  x_cur;
   logic signed [XY_W-1:0]  y_cur;
   logic signed [Z_W-1:0]   z_cur;
   logic signed [PROD_W-1:0] x_fin;
   logic signed [PROD_W-1:0] y_fin;
   logic signed [Z_W:0]     z_fin;

   // stage A: gain multiply and pi correction of the vectoring angle
   always_comb begin
      x_cur     = in_data.x;
      y_cur     = in_data.y;
      z_cur     = in_data.z;
      prod_x_in = PROD_W'(x_cur) * PROD_W'(GAIN_S);
      prod_y_in = PROD_W'(y_cur) * PROD_W'(GAIN_S);
      z_in      = z_cur;
      if (in_data.fix_pi) begin
         z_in = in_data.pi_neg ? (z_cur - PI_AP_Z) : (z_cur + PI_AP_Z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_mode_ff   <= in_data.vec_mode;
         bypass_ff     <= in_data.bypass;
         status_ff     <= in_data.status;
         byp_first_ff  <= in_data.byp_first;
         byp_second_ff <= in_data.byp_second;
         prod_x_ff     <= prod_x_in;
         prod_y_ff     <= prod_y_in;
         z_ff          <= z_in;
      end
   end

   // stage B: round half up, saturate, select
   always_comb begin
      x_fin = (prod_x_ff + PROD_RND) >>> GAIN_SHIFT;
      y_fin = (prod_y_ff + PROD_RND) >>> GAIN_SHIFT;
      z_fin = ((Z_W + 1)'(z_ff) + ANG_RND) >>> ANG_SHIFT;
      if (bypass_ff) begin
         first_result  = byp_first_ff;
         second_result = byp_second_ff;
      end else if (vec_mode_ff) begin
         first_result  = sat_res(64'(x_fin));
         second_result = sat_res(64'(z_fin));
      end else begin
         first_result  = sat_res(64'(x_fin));
         second_result = sat_res(64'(y_fin));
      end
   end

   assign out_valid = valid_ff;
   assign status    = status_ff;

endmodule

>>> rtl/core/polar_cartesian_converter_unit.sv
// ----------------------------------------------------------------------------
// polar_cartesian_converter_unit
// Polar <-> cartesian conversion in signed Q4.12 on an unrolled CORDIC chain.
// ----------------------------------------------------------------------------
// Takes one coordinate pair per clock while req_stall is low and returns one
// result per pair, in order. The pipeline holds one input stage, one cell per
// CORDIC iteration, one gain-multiply stage and the output register. Throughput
// is set by the cell chain, which advances every cycle unless the output skid
// register is occupied; a result may wait on rsp_stall while the next one is
// still taken in. No reset sweep, no configuration.
// ----------------------------------------------------------------------------
module polar_cartesian_converter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic signed [pcc_pkg::IN_W-1:0]   req_first_value,
   input  logic signed [pcc_pkg::IN_W-1:0]   req_second_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pcc_pkg::RES_W-1:0]  rsp_first_result,
   output logic signed [pcc_pkg::RES_W-1:0]  rsp_second_result,
   output logic [1:0]                        rsp_status
);
   import pcc_pkg::*;

   logic                    adv;
   logic                    chain_valid [ITER_USED+1];
   pcc_data_type            chain_data  [ITER_USED+1];
   logic                    fin_valid;
   logic signed [RES_W-1:0] fin_first;
   logic signed [RES_W-1:0] fin_second;
   logic [1:0]              fin_status;

   logic                    rsp_valid_ff,  rsp_valid_in;
   logic signed [RES_W-1:0] rsp_first_ff,  rsp_first_in;
   logic signed [RES_W-1:0] rsp_second_ff, rsp_second_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    skid_full_ff,  skid_full_in;
   logic signed [RES_W-1:0] skid_first_ff, skid_first_in;
   logic signed [RES_W-1:0] skid_second_ff, skid_second_in;
   logic [1:0]              skid_status_ff, skid_status_in;

   assign adv = !skid_full_ff;

   pcc_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .enable       (adv),
      .in_valid     (req_valid),
      .cmd          (req_cmd),
      .first_value  (req_first_value),
      .second_value (req_second_value),
      .out_valid    (chain_valid[0]),
      .out_data     (chain_data[0])
   );

   for (genvar g = 0; g < ITER_USED; g++) begin : g_cell
      pcc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (adv),
         .shift     (IDX_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   pcc_post u_post (
      .clock         (clock),
      .reset         (reset),
      .enable        (adv),
      .in_valid      (chain_valid[ITER_USED]),
      .in_data       (chain_data[ITER_USED]),
      .out_valid     (fin_valid),
      .first_result  (fin_first),
      .second_result (fin_second),
      .status        (fin_status)
   );

   // output register with one skid entry; the chain halts only while the skid holds
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_second_in  = rsp_second_ff;
      rsp_status_in  = rsp_status_ff;
      skid_full_in   = skid_full_ff;
      skid_first_in  = skid_first_ff;
      skid_second_in = skid_second_ff;
      skid_status_in = skid_status_ff;
      if (skid_full_ff) begin
         if (!rsp_stall) begin
            rsp_first_in  = skid_first_ff;
            rsp_second_in = skid_second_ff;
            rsp_status_in = skid_status_ff;
            skid_full_in  = 1'b0;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in  = fin_valid;
         rsp_first_in  = fin_first;
         rsp_second_in = fin_second;
         rsp_status_in = fin_status;
      end else if (fin_valid) begin
         skid_full_in   = 1'b1;
         skid_first_in  = fin_first;
         skid_second_in = fin_second;
         skid_status_in = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_first_ff   <= rsp_first_in;
      rsp_second_ff  <= rsp_second_in;
      rsp_status_ff  <= rsp_status_in;
      skid_first_ff  <= skid_first_in;
      skid_second_ff <= skid_second_in;
      skid_status_ff <= skid_status_in;
   end

   assign req_stall         = skid_full_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_result  = rsp_first_ff;
   assign rsp_second_result = rsp_second_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> rtl/core/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [pcc_pkg::RES_W-1:0]  rsp_first_result,
   input  logic signed [pcc_pkg::RES_W-1:0]  rsp_second_result,
   input  logic [1:0]                        rsp_status
);
   import pcc_pkg::*;

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_first_result)
         && $stable(rsp_second_result) && $stable(rsp_status))
      else $error("result changed while stalled");

   // an error status carries zero coordinates
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_first_result == '0 && rsp_second_result == '0)
      else $error("error result with nonzero coordinates");

   // input backpressure only appears behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // nothing leaves the block right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output active after reset");

endmodule

bind polar_cartesian_converter_unit pcc_checker u_pcc_checker (.*);
